### src/tmmm_pkg.sv
// shared constants for the temporal median motion mask unit
package tmmm_pkg;
   localparam int MAX_HISTORY  = 20;
   localparam int PIX_W        = 8;
   localparam int IDX_W        = 20;
   localparam int HIST_W       = 5;
   localparam int SLOT_W       = 5;
   localparam int CNT_W        = 6;
   localparam int FRAME_PIXELS = 1 << IDX_W;
   localparam int WORD_W       = MAX_HISTORY * PIX_W;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;
   localparam int LATENCY      = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_THRESHOLD = 1'b1;

   localparam logic [HIST_W-1:0]     HIST_RESET   = HIST_W'(10);
   localparam logic [PIX_W-1:0]      THR_RESET    = PIX_W'(10);
   localparam logic [HIST_W-1:0]     HIST_MAX     = HIST_W'(MAX_HISTORY);
   localparam logic [SLOT_W-1:0]     SLOT_LAST    = SLOT_W'(MAX_HISTORY - 1);
endpackage

### src/temporal_median_motion_mask_unit.sv
// temporal median background subtraction with a per-pixel frame history
//
// pixels enter on the req_ channel (valid/stall) in raster order, one item a
// cycle when not stalled; each item yields one rsp_ item with the foreground
// flag, the background estimate and the echoed index. the history of every
// raster position is one wide memory word holding one byte per frame slot;
// the word is read and the new byte written at the edge the item is accepted,
// so a repeated index sees the earlier write right away.
// throughput is one item per cycle while no result waits under rsp_stall; the
// median is found by pairwise compares, rank counts and a rank match, one
// pipeline stage each.
// the whole pipeline advances together: while a result waits under
// rsp_stall, req_stall is raised and every stage holds, so nothing is lost.
// reset empties the pipeline, clears the frame count and slot pointer and
// loads history_length 10 and diff_threshold 10; the history memory is not
// cleared, entries of frames not yet seen are never used. the user must give
// csr_ port writes only while the unit is idle; the unit does not check it.
module temporal_median_motion_mask_unit
   import tmmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_value,
   input  logic [IDX_W-1:0]      req_pixel_index,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_foreground,
   output logic [PIX_W-1:0]      rsp_background_value,
   output logic [IDX_W-1:0]      rsp_out_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   logic [WORD_W-1:0] history_ff [FRAME_PIXELS];

   logic [HIST_W-1:0] hist_len_ff, hist_len_in;
   logic [PIX_W-1:0]  thr_ff, thr_in;
   logic [HIST_W-1:0] held_ff, held_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic adv, accept;
   logic [HIST_W-1:0] n_eff, h_cur, h_next;
   logic [PIX_W-1:0]  t_eff;

   // stage 1
   logic              v1_ff;
   logic [WORD_W-1:0] rd_ff;
   logic [PIX_W-1:0]  pix1_ff;
   logic [IDX_W-1:0]  idx1_ff;
   logic [HIST_W-1:0] h1_ff;
   logic [SLOT_W-1:0] slot1_ff;
   // stage 2
   logic                   v2_ff;
   logic [PIX_W-1:0]       vals2_ff [MAX_HISTORY];
   logic [MAX_HISTORY-1:0] sel2_ff, sel2_in;
   logic [MAX_HISTORY-1:0] lt2_ff [MAX_HISTORY];
   logic [MAX_HISTORY-1:0] eq2_ff [MAX_HISTORY];
   logic [MAX_HISTORY-1:0] lt2_in [MAX_HISTORY];
   logic [MAX_HISTORY-1:0] eq2_in [MAX_HISTORY];
   logic [PIX_W-1:0]       pix2_ff;
   logic [IDX_W-1:0]       idx2_ff;
   logic [HIST_W-1:0]      h2_ff;
   // stage 3
   logic                   v3_ff;
   logic [PIX_W-1:0]       vals3_ff [MAX_HISTORY];
   logic [MAX_HISTORY-1:0] sel3_ff;
   logic [HIST_W-1:0]      ltc3_ff [MAX_HISTORY];
   logic [HIST_W-1:0]      eqc3_ff [MAX_HISTORY];
   logic [PIX_W-1:0]       pix3_ff;
   logic [IDX_W-1:0]       idx3_ff;
   logic [HIST_W-1:0]      h3_ff;
   // stage 4
   logic              v4_ff;
   logic [PIX_W-1:0]  lo4_ff, hi4_ff, lo4_in, hi4_in;
   logic [PIX_W-1:0]  pix4_ff;
   logic [IDX_W-1:0]  idx4_ff;
   logic [HIST_W-1:0] h4_ff;
   // stage 5
   logic              v5_ff;
   logic              fg5_ff, fg5_in;
   logic [PIX_W-1:0]  bg5_ff, bg5_in;
   logic [IDX_W-1:0]  idx5_ff;

   assign adv       = !(v5_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      if (hist_len_ff == '0) n_eff = HIST_W'(1);
      else if (hist_len_ff > HIST_MAX) n_eff = HIST_MAX;
      else n_eff = hist_len_ff;
      t_eff = (thr_ff == '0) ? PIX_W'(1) : thr_ff;
      h_cur = (held_ff < n_eff) ? held_ff : n_eff;
      h_next = (h_cur == HIST_MAX) ? HIST_MAX : h_cur + HIST_W'(1);
   end

   always_comb begin
      hist_len_in = hist_len_ff;
      thr_in      = thr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HISTORY_LENGTH: hist_len_in = csr_write_data[HIST_W-1:0];
            CSR_DIFF_THRESHOLD: thr_in      = csr_write_data;
            default: ;
         endcase
      end
      held_in = held_ff;
      slot_in = slot_ff;
      if (accept && req_frame_end) begin
         held_in = h_next;
         slot_in = (slot_ff >= SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= HIST_RESET;
         thr_ff      <= THR_RESET;
         held_ff     <= '0;
         slot_ff     <= '0;
      end else begin
         hist_len_ff <= hist_len_in;
         thr_ff      <= thr_in;
         held_ff     <= held_in;
         slot_ff     <= slot_in;
      end
   end

   // history memory: read old word and write the new byte at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= history_ff[req_pixel_index];
         history_ff[req_pixel_index][slot_ff*PIX_W +: PIX_W] <= req_pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= req_pixel_value;
         idx1_ff  <= req_pixel_index;
         h1_ff    <= h_cur;
         slot1_ff <= slot_ff;
      end
   end

   // slots selected are the h most recent ones before the write slot
   always_comb begin
      logic [CNT_W-1:0] slot_age;
      for (int j = 0; j < MAX_HISTORY; j++) begin
         slot_age = CNT_W'(slot1_ff) + CNT_W'(MAX_HISTORY - 1 - j);
         if (slot_age >= CNT_W'(MAX_HISTORY)) slot_age = slot_age - CNT_W'(MAX_HISTORY);
         sel2_in[j] = slot_age < CNT_W'(h1_ff);
      end
      for (int i = 0; i < MAX_HISTORY; i++) begin
         for (int j = 0; j < MAX_HISTORY; j++) begin
            lt2_in[i][j] = sel2_in[j] &&
               (rd_ff[j*PIX_W +: PIX_W] < rd_ff[i*PIX_W +: PIX_W]);
            eq2_in[i][j] = sel2_in[j] &&
               (rd_ff[j*PIX_W +: PIX_W] == rd_ff[i*PIX_W +: PIX_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < MAX_HISTORY; i++) begin
            vals2_ff[i] <= rd_ff[i*PIX_W +: PIX_W];
            lt2_ff[i]   <= lt2_in[i];
            eq2_ff[i]   <= eq2_in[i];
         end
         sel2_ff <= sel2_in;
         pix2_ff <= pix1_ff;
         idx2_ff <= idx1_ff;
         h2_ff   <= h1_ff;
      end
   end

   // rank counts per element
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < MAX_HISTORY; i++) begin
            vals3_ff[i] <= vals2_ff[i];
            ltc3_ff[i]  <= HIST_W'($countones(lt2_ff[i]));
            eqc3_ff[i]  <= HIST_W'($countones(eq2_ff[i]));
         end
         sel3_ff <= sel2_ff;
         pix3_ff <= pix2_ff;
         idx3_ff <= idx2_ff;
         h3_ff   <= h2_ff;
      end
   end

   // pick the values holding the two middle ranks (one rank when h is odd)
   always_comb begin
      logic [CNT_W-1:0] m_hi, m_lo, top;
      m_hi = CNT_W'(h3_ff >> 1);
      m_lo = h3_ff[0] ? m_hi : m_hi - CNT_W'(1);
      lo4_in = '0;
      hi4_in = '0;
      for (int i = 0; i < MAX_HISTORY; i++) begin
         top = CNT_W'(ltc3_ff[i]) + CNT_W'(eqc3_ff[i]);
         if (sel3_ff[i] && CNT_W'(ltc3_ff[i]) <= m_hi && m_hi < top)
            hi4_in = hi4_in | vals3_ff[i];
         if (sel3_ff[i] && CNT_W'(ltc3_ff[i]) <= m_lo && m_lo < top)
            lo4_in = lo4_in | vals3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo4_ff  <= lo4_in;
         hi4_ff  <= hi4_in;
         pix4_ff <= pix3_ff;
         idx4_ff <= idx3_ff;
         h4_ff   <= h3_ff;
      end
   end

   always_comb begin
      logic [PIX_W:0]   sum;
      logic [PIX_W-1:0] half;
      logic [PIX_W-1:0] diff;
      sum  = {1'b0, lo4_ff} + {1'b0, hi4_ff};
      half = sum[PIX_W:1];
      if (h4_ff == '0) bg5_in = '0;
      else if (h4_ff[0]) bg5_in = hi4_ff;
      else if (h4_ff == HIST_W'(2)) bg5_in = half + PIX_W'(sum[0] & half[0]);
      else bg5_in = half;
      diff   = (pix4_ff > bg5_in) ? pix4_ff - bg5_in : bg5_in - pix4_ff;
      fg5_in = (h4_ff != '0) && (diff > t_eff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fg5_ff  <= fg5_in;
         bg5_ff  <= bg5_in;
         idx5_ff <= idx4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign rsp_valid            = v5_ff;
   assign rsp_foreground       = fg5_ff;
   assign rsp_background_value = bg5_ff;
   assign rsp_out_index        = idx5_ff;
endmodule

### src/tmmm_checker.sv
// port-level checks for the temporal median motion mask unit
module tmmm_checker
   import tmmm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_foreground,
   input logic [PIX_W-1:0]      rsp_background_value,
   input logic [IDX_W-1:0]      rsp_out_index
);
   // an empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // input only held back by a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // a stalled result keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_foreground) &&
      $stable(rsp_background_value) && $stable(rsp_out_index)))
      else $error("stalled result changed");

   // a free-running output drains: no result appears without an earlier item
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result without an item");
endmodule

bind temporal_median_motion_mask_unit tmmm_checker u_tmmm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_foreground       (rsp_foreground),
   .rsp_background_value (rsp_background_value),
   .rsp_out_index        (rsp_out_index)
);

### tb/sv/motion_mask_checker.sv
// result checker for the temporal median motion mask unit: predicts and compares
module motion_mask_checker
   import tmmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_value,
   input  logic [IDX_W-1:0]      req_pixel_index,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_foreground,
   input  logic [PIX_W-1:0]      rsp_background_value,
   input  logic [IDX_W-1:0]      rsp_out_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    errors,
   output int                    pending,
   output int                    masks_seen,
   output int                    foreground_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             fg;
      logic [PIX_W-1:0] bg;
      logic [IDX_W-1:0] idx;
   } mask_result_type;

   mask_result_type expected_masks[$];
   logic [PIX_W-1:0] pixel_history [logic [SLOT_W+IDX_W-1:0]];
   logic [HIST_W-1:0] frames_seen;
   logic [SLOT_W-1:0] cur_slot;
   logic [HIST_W-1:0] hist_len_reg;
   logic [PIX_W-1:0]  thr_reg;

   function automatic mask_result_type predict_mask(input logic [PIX_W-1:0] pix,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic fend);
      int n, t, h, slot, s, bg, d;
      logic [PIX_W-1:0] vals[MAX_HISTORY];
      logic [PIX_W-1:0] tmp;
      mask_result_type r;
      n = hist_len_reg;
      if (n < 1) n = 1;
      if (n > MAX_HISTORY) n = MAX_HISTORY;
      t = thr_reg;
      if (t < 1) t = 1;
      h = (frames_seen < n) ? frames_seen : n;
      for (int k = 0; k < h; k++) begin
         slot = (cur_slot + MAX_HISTORY - 1 - k) % MAX_HISTORY;
         vals[k] = pixel_history[{SLOT_W'(slot), idx}];
      end
      for (int i = 0; i < h; i++)
         for (int j = 0; j < h - 1 - i; j++)
            if (vals[j] > vals[j+1]) begin
               tmp = vals[j];
               vals[j] = vals[j+1];
               vals[j+1] = tmp;
            end
      if (h == 0) bg = 0;
      else if (h == 1) bg = vals[0];
      else if (h == 2) begin
         // mean rounded half to even
         s = vals[0] + vals[1];
         bg = s >> 1;
         if ((s & 1) && (bg & 1)) bg++;
      end else if (h & 1) bg = vals[h/2];
      else bg = (vals[h/2] + vals[h/2-1]) >> 1;
      d = (pix > bg) ? pix - bg : bg - pix;
      r.fg = (h != 0) && (d > t);
      r.bg = PIX_W'(bg);
      r.idx = idx;
      pixel_history[{cur_slot, idx}] = pix;
      if (fend) begin
         frames_seen = (h + 1 > MAX_HISTORY) ? HIST_MAX : HIST_W'(h + 1);
         cur_slot = (cur_slot == SLOT_LAST) ? '0 : cur_slot + 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      mask_result_type got, want;
      if (reset) begin
         expected_masks.delete();
         frames_seen = '0;
         cur_slot = '0;
         hist_len_reg = HIST_RESET;
         thr_reg = THR_RESET;
         errors <= 0;
         pending <= 0;
         masks_seen <= 0;
         foreground_seen <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_HISTORY_LENGTH) hist_len_reg = csr_write_data[HIST_W-1:0];
            else if (csr_index == CSR_DIFF_THRESHOLD) thr_reg = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_foreground, rsp_background_value, rsp_out_index};
            masks_seen <= masks_seen + 1;
            if (rsp_foreground) foreground_seen <= foreground_seen + 1;
            if (expected_masks.size() == 0) begin
               $display("%0t: unexpected item fg=%0d bg=%0d idx=%h", $time,
                        got.fg, got.bg, got.idx);
               errors <= errors + 1;
            end else begin
               want = expected_masks[0];
               expected_masks.delete(0);
               if (got !== want) begin
                  $display("%0t: mismatch expected fg=%0d bg=%0d idx=%h,",
                           $time, want.fg, want.bg, want.idx,
                           " got fg=%0d bg=%0d idx=%h", got.fg, got.bg, got.idx);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_masks.insert(expected_masks.size(),
                                  predict_mask(req_pixel_value, req_pixel_index,
                                               req_frame_end));
         pending <= expected_masks.size();
      end
   end
endmodule

### tb/sv/testbench.sv
// top of the motion mask testbench: clock, reset, stimulus and verdict
module testbench;
   import tmmm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_POS = 8;
   localparam int FRAMES_PER_PHASE = 10;
   localparam int NUM_PHASES = 9;
   localparam int IDLE_LIMIT = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic [IDX_W-1:0]      req_pixel_index = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_foreground;
   logic [PIX_W-1:0]      rsp_background_value;
   logic [IDX_W-1:0]      rsp_out_index;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int errors, pending, masks_seen, foreground_seen;
   int sent_items = 0;
   bit sender_idles = 0, receiver_stalls = 0;
   int idle_pct = 72;
   int hold_left = 0;
   bit hold_done = 0;
   int quiet_cycles = 0;

   // the position set is the same in every frame, so no unwritten entry is read
   logic [IDX_W-1:0] positions[NUM_POS];
   logic [PIX_W-1:0] scene[NUM_POS];

   int hist_plan[NUM_PHASES] = '{10, 1, 2, 0, 3, 31, 4, 20, 7};
   int thr_plan[NUM_PHASES]  = '{10, 5, 255, 0, 1, 20, 3, 40, 12};

   temporal_median_motion_mask_unit i_dut (.*);

   motion_mask_checker i_checker (.*);

   always #10 clock = ~clock;

   // receiver side: random stalls plus one long hold-off to back up the pipeline
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_items == 40) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         hold_done <= 1;
      end else rsp_stall <= receiver_stalls && ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL temporal_median_motion_mask_unit");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [IDX_W-1:0] idx,
                             input logic fend);
      bit taken;
      while (sender_idles && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pix;
      req_pixel_index <= idx;
      req_frame_end <= fend;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sent_items++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic send_frame(input bit extremes, input int thr);
      int order[$];
      int n, p, spread, v;
      for (int i = 0; i < NUM_POS; i++) order.insert(order.size(), i);
      order.shuffle();
      // repeated positions within a frame read back the earlier write
      n = $urandom_range(3);
      for (int i = 0; i < n; i++)
         order.insert($urandom_range(order.size() - 1), $urandom_range(NUM_POS - 1));
      spread = (thr > 60) ? 60 : thr + 3;
      foreach (order[i]) begin
         p = order[i];
         if (extremes) v = (i & 1) ? 255 : 0;
         else if ($urandom_range(99) < 20) v = $urandom_range(255);
         else begin
            if ($urandom_range(99) < 5) scene[p] = PIX_W'($urandom_range(255));
            v = scene[p] + $urandom_range(2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         send_pixel(PIX_W'(v), positions[p], i == order.size() - 1);
      end
   endtask

   initial begin
      positions[0] = '0;
      positions[1] = '1;
      positions[2] = 20'h55555;
      positions[3] = 20'hAAAAA;
      for (int i = 4; i < NUM_POS; i++)
         positions[i] = IDX_W'($urandom_range(FRAME_PIXELS - 1));
      foreach (scene[i]) scene[i] = PIX_W'($urandom_range(255));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph != 0) begin
            write_reg(CSR_HISTORY_LENGTH, hist_plan[ph]);
            write_reg(CSR_DIFF_THRESHOLD, thr_plan[ph]);
         end
         sender_idles = (ph % 4 == 1) || (ph % 4 == 3);
         receiver_stalls = (ph % 4 == 2) || (ph % 4 == 3);
         idle_pct = (ph % 4 == 3) ? 36 : 72;
         // phase 0 starts with frames of extreme grey levels, first with no history
         for (int f = 0; f < FRAMES_PER_PHASE; f++)
            send_frame(ph == 0 && f < 3, thr_plan[ph]);
         drain_pipeline();
      end
      $display("covered %0d pixels in %0d phases of history length and threshold",
               sent_items, NUM_PHASES);
      $display("%0d results checked, %0d of them foreground", masks_seen, foreground_seen);
      if (errors == 0) $display("PASS temporal_median_motion_mask_unit");
      else $display("FAIL temporal_median_motion_mask_unit");
      $finish;
   end
endmodule
